>>> rtl/det_pkg.sv
// ----------------------------------------------------------------------------
// det_pkg: shared types and constants of the directory entry table
// Holds the table geometry, the request and response beats, the operation
// and status codes, and the layout of one stored row.
// ----------------------------------------------------------------------------
package det_pkg;

	localparam int ENTRIES    = 128;
	localparam int NAME_BYTES = 32;

	// Port words always carry 32 name bytes; only NAME_BYTES of them are kept.
	localparam int PORT_BYTES = 32;
	localparam int PORT_W     = PORT_BYTES * 8;
	localparam int NAME_W     = NAME_BYTES * 8;
	localparam int INO_W      = 32;
	localparam int ROW_W      = INO_W + NAME_W;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_RENAME  = 3'd2,
		OP_BY_INO  = 3'd3,
		OP_BY_NAME = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef logic [3:0][63:0] name_words_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] ino;
		logic [63:0] name_w0;
		logic [63:0] name_w1;
		logic [63:0] name_w2;
		logic [63:0] name_w3;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] ino_out;
		logic [63:0] name_out_w0;
		logic [63:0] name_out_w1;
		logic [63:0] name_out_w2;
		logic [63:0] name_out_w3;
		logic [7:0]  used_count;
	} rsp_t;

	typedef struct packed {
		logic [INO_W-1:0]  ino;
		logic [NAME_W-1:0] name;
	} row_t;

endpackage

>>> rtl/directory_entry_table.sv
// ----------------------------------------------------------------------------
// directory_entry_table: fixed table of directory entries
// Add, remove, rename and look up entries by inode or by name.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel (req_valid / req_ready / req) and
// each one produces exactly one response beat on the rsp channel (rsp_valid /
// rsp_ready / rsp). A request beat is taken only while the controller is idle;
// the block works on one request at a time.
//
// Flow. After a request beat, the prep state cleans and checks the name. A
// request that fails early (invalid name, full count, unknown operation) then
// goes straight to the response stage. Every other request walks the row RAM
// one row per cycle through its single read port and stops at the first
// matching row; then its response beat is loaded.
//
// Reset. arst_n clears the per-row used flags, the entry count and the
// response register, so every row reads as free and the count as zero. The
// RAM itself needs no clearing pass: its contents are only looked at for rows
// whose used flag is set.
//
// Stalls. The response sits in an output register; the block takes the next
// request while that beat waits. A second response waits in the final stage,
// with its write-back held back, until the receiver takes the first.
// ----------------------------------------------------------------------------
module directory_entry_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  det_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output det_pkg::rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_DONE
	} state_t;

	localparam logic [det_pkg::IDX_W-1:0] LAST_ROW = det_pkg::IDX_W'(det_pkg::ENTRIES - 1);
	localparam logic [det_pkg::CNT_W-1:0] FULL_CNT = det_pkg::CNT_W'(det_pkg::ENTRIES);

	state_t state_q;

	// Control state.
	logic                        rsp_valid_q;
	det_pkg::rsp_t               rsp_q;
	logic [det_pkg::ENTRIES-1:0] used_q;
	logic [det_pkg::CNT_W-1:0]   count_q;
	logic                        issue_done_q;
	logic                        pend_s1;

	// Request payload and scan bookkeeping.
	det_pkg::req_t             req_q;
	logic [det_pkg::NAME_W-1:0] clean_q;
	logic [det_pkg::IDX_W-1:0] idx_q;
	logic [det_pkg::IDX_W-1:0] row_s1;
	logic [det_pkg::IDX_W-1:0] hit_row_q;
	det_pkg::row_t             hit_data_q;
	det_pkg::status_t          status_q;

	// Name normalizer on the captured request.
	det_pkg::name_words_t       raw_name;
	logic [det_pkg::NAME_W-1:0] clean_name;
	logic                       name_ok;

	assign raw_name = {req_q.name_w3, req_q.name_w2, req_q.name_w1, req_q.name_w0};

	det_name_clean u_clean (
		.raw   (raw_name),
		.clean (clean_name),
		.valid (name_ok)
	);

	// Row RAM: inode and clean name of every row.
	logic                         ram_wr_en;
	logic [det_pkg::ROW_W-1:0]    ram_wr_data;
	logic                         ram_rd_en;
	logic [det_pkg::ROW_W-1:0]    ram_rd_data;
	det_pkg::row_t                rd_row;
	det_pkg::row_t                wr_row;

	det_ram #(
		.DEPTH (det_pkg::ENTRIES),
		.WIDTH (det_pkg::ROW_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (hit_row_q),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

	assign rd_row    = det_pkg::row_t'(ram_rd_data);
	assign ram_rd_en = (state_q == S_SCAN) && !issue_done_q;

	// Match test on the row read back from the RAM in the previous cycle.
	det_pkg::op_t op;
	logic         row_used;
	logic         row_hit;
	logic         scan_end;

	assign op       = det_pkg::op_t'(req_q.op);
	assign row_used = used_q[row_s1];

	always_comb begin
		unique case (op)
			det_pkg::OP_ADD:     row_hit = !row_used;
			det_pkg::OP_REMOVE,
			det_pkg::OP_RENAME,
			det_pkg::OP_BY_INO:  row_hit = row_used && (rd_row.ino == req_q.ino);
			det_pkg::OP_BY_NAME: row_hit = row_used && (rd_row.name == clean_q);
			default:             row_hit = 1'b0;
		endcase
	end

	assign scan_end = pend_s1 && (row_hit || (row_s1 == LAST_ROW));

	// Final stage: write-back and response load, held while the output is full.
	logic                       fire;
	logic                       done_ok;
	logic [det_pkg::CNT_W-1:0]  count_next;
	logic [15:0]                count_wide;
	logic [det_pkg::PORT_W-1:0] name_wide;
	det_pkg::rsp_t              rsp_next;

	assign fire    = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign done_ok = (status_q == det_pkg::ST_OK);

	assign wr_row.ino  = (op == det_pkg::OP_ADD) ? req_q.ino : hit_data_q.ino;
	assign wr_row.name = clean_q;
	assign ram_wr_data = wr_row;
	assign ram_wr_en   = fire && done_ok &&
	                     ((op == det_pkg::OP_ADD) || (op == det_pkg::OP_RENAME));

	always_comb begin
		count_next = count_q;
		if (done_ok && (op == det_pkg::OP_ADD)) begin
			count_next = count_q + det_pkg::CNT_W'(1);
		end else if (done_ok && (op == det_pkg::OP_REMOVE) && (count_q != '0)) begin
			count_next = count_q - det_pkg::CNT_W'(1);
		end
	end

	assign count_wide = 16'(count_next);
	assign name_wide  = (done_ok && (op == det_pkg::OP_BY_INO)) ?
	                    det_pkg::PORT_W'(hit_data_q.name) : '0;

	always_comb begin
		rsp_next.status      = status_q;
		rsp_next.ino_out     = (done_ok && (op == det_pkg::OP_BY_NAME)) ? hit_data_q.ino : '0;
		rsp_next.name_out_w0 = name_wide[63:0];
		rsp_next.name_out_w1 = name_wide[127:64];
		rsp_next.name_out_w2 = name_wide[191:128];
		rsp_next.name_out_w3 = name_wide[255:192];
		rsp_next.used_count  = count_wide[7:0];
	end

	// Early verdict taken while the name is being cleaned. An add that scans
	// the whole table without finding a free row answers full.
	logic             prep_scan;
	det_pkg::status_t prep_status;

	always_comb begin
		prep_scan   = 1'b0;
		prep_status = det_pkg::ST_NOTFOUND;
		unique case (op)
			det_pkg::OP_ADD: begin
				if (!name_ok) begin
					prep_status = det_pkg::ST_INVALID;
				end else if (count_q >= FULL_CNT) begin
					prep_status = det_pkg::ST_FULL;
				end else begin
					prep_status = det_pkg::ST_FULL;
					prep_scan   = 1'b1;
				end
			end
			det_pkg::OP_REMOVE,
			det_pkg::OP_BY_INO: begin
				prep_scan = 1'b1;
			end
			det_pkg::OP_RENAME,
			det_pkg::OP_BY_NAME: begin
				if (!name_ok) begin
					prep_status = det_pkg::ST_INVALID;
				end else begin
					prep_scan = 1'b1;
				end
			end
			default: begin
				prep_scan = 1'b0;
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// State, used flags, count and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			used_q       <= '0;
			count_q      <= '0;
			issue_done_q <= 1'b0;
			pend_s1      <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && !fire) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (req_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					issue_done_q <= 1'b0;
					pend_s1      <= 1'b0;
					state_q      <= prep_scan ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					pend_s1 <= ram_rd_en && !scan_end;
					if (ram_rd_en && (idx_q == LAST_ROW)) begin
						issue_done_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (fire) begin
						rsp_q       <= rsp_next;
						rsp_valid_q <= 1'b1;
						count_q     <= count_next;
						if (done_ok && (op == det_pkg::OP_ADD)) begin
							used_q[hit_row_q] <= 1'b1;
						end else if (done_ok && (op == det_pkg::OP_REMOVE)) begin
							used_q[hit_row_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload, scan address and the captured hit row.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == S_PREP) begin
			clean_q  <= clean_name;
			idx_q    <= '0;
			status_q <= prep_status;
		end
		if (ram_rd_en) begin
			row_s1 <= idx_q;
			if (idx_q != LAST_ROW) begin
				idx_q <= idx_q + det_pkg::IDX_W'(1);
			end
		end
		if ((state_q == S_SCAN) && pend_s1 && row_hit) begin
			hit_row_q  <= row_s1;
			hit_data_q <= rd_row;
			status_q   <= det_pkg::ST_OK;
		end
	end

endmodule

>>> rtl/det_name_clean.sv
// ----------------------------------------------------------------------------
// det_name_clean: name normalizer
// Zeroes every byte from the first zero byte on, drops bytes past the name
// length, and flags a name that is empty or has no terminating zero.
// ----------------------------------------------------------------------------
module det_name_clean (
	input  det_pkg::name_words_t        raw,
	output logic [det_pkg::NAME_W-1:0]  clean,
	output logic                        valid
);

	logic [det_pkg::PORT_W-1:0]     flat;
	logic [det_pkg::NAME_BYTES-1:0] zb;
	logic [det_pkg::NAME_BYTES-1:0] seen;

	assign flat = raw;

	always_comb begin
		for (int i = 0; i < det_pkg::NAME_BYTES; i++) begin
			zb[i] = (flat[8*i +: 8] == 8'h00);
		end
		// A byte survives only if no zero byte sits at or below it.
		for (int i = 0; i < det_pkg::NAME_BYTES; i++) begin
			seen[i] = 1'b0;
			for (int j = 0; j <= i; j++) begin
				seen[i] = seen[i] | zb[j];
			end
			clean[8*i +: 8] = seen[i] ? 8'h00 : flat[8*i +: 8];
		end
		valid = !zb[0] && (|zb);
	end

endmodule

>>> rtl/det_ram.sv
// ----------------------------------------------------------------------------
// det_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module det_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 288,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
